>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the bus decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define HCBD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define HCBD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define HCBD_ASSERT(label, clk, rst, prop, msg)

`define HCBD_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

>>> rtl/core/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, I/O register codes and helpers for the console bus decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbd_pkg;

   localparam int RAM_BANKS_DEFAULT      = 8;
   localparam int HIGH_RAM_BYTES_DEFAULT = 127;
   localparam int BANK_BYTES             = 4096;

   localparam logic [7:0] BYTE_ONES  = 8'hFF;
   localparam logic [7:0] BYTE_ZERO  = 8'h00;

   localparam logic [7:0] IO_PAD       = 8'h00;
   localparam logic [7:0] IO_TIMER_LO  = 8'h04;
   localparam logic [7:0] IO_TIMER_HI  = 8'h07;
   localparam logic [7:0] IO_IFLAG     = 8'h0F;
   localparam logic [7:0] IO_APU_LO    = 8'h10;
   localparam logic [7:0] IO_APU_HI    = 8'h27;
   localparam logic [7:0] IO_WAVE_LO   = 8'h30;
   localparam logic [7:0] IO_WAVE_HI   = 8'h3F;
   localparam logic [7:0] IO_PPU_LO    = 8'h40;
   localparam logic [7:0] IO_PPU_HI    = 8'h4B;
   localparam logic [7:0] IO_LY        = 8'h44;
   localparam logic [7:0] IO_MODE      = 8'h4C;
   localparam logic [7:0] IO_SPEED     = 8'h4D;
   localparam logic [7:0] IO_VBANK     = 8'h4F;
   localparam logic [7:0] IO_BOOT      = 8'h50;
   localparam logic [7:0] IO_DMA_LO    = 8'h51;
   localparam logic [7:0] IO_DMA_HI    = 8'h55;
   localparam logic [7:0] IO_PAL_LO    = 8'h68;
   localparam logic [7:0] IO_PAL_HI    = 8'h6C;
   localparam logic [7:0] IO_BANK      = 8'h70;
   localparam logic [7:0] IO_HRAM_LO   = 8'h80;
   localparam logic [7:0] IO_HRAM_HI   = 8'hFE;
   localparam logic [7:0] IO_IE        = 8'hFF;

   localparam int MODE_COMPAT_BIT = 2;

   typedef enum logic [3:0] {
      TGT_LOCAL, TGT_BOOT, TGT_CROM, TGT_VRAM, TGT_CRAM, TGT_OAM, TGT_PAD,
      TGT_TIMER, TGT_IFLAG, TGT_APU, TGT_WAVE, TGT_PPU, TGT_SPEED, TGT_DMA, TGT_IE
   } tgt_type;

   typedef enum logic [1:0] {
      SRC_CONST, SRC_WRAM, SRC_HRAM
   } src_type;

   typedef struct packed {
      logic       boot_mapped;
      logic       cart_present;
      logic [7:0] mode_byte;
      logic [2:0] ram_bank;
   } state_type;

   typedef struct packed {
      tgt_type     target;
      logic [14:0] offset;
      logic [7:0]  forward_data;
      logic [7:0]  const_data;
      logic        local_valid;
      src_type     src;
      logic        is_write;
      logic        wram_hit;
      logic        hram_hit;
      logic        mode_we;
      logic        boot_clear;
      logic        bank_we;
      logic [2:0]  bank_value;
   } decode_type;

   // Reduces a bank number modulo the number of banks by up to three subtractions, a full modulo for two banks or more.
   function automatic logic [2:0] bank_wrap(input logic [2:0] bank, input logic [3:0] banks);
      logic [2:0] v;
      v = bank;
      for (int i = 0; i < 3; i++) begin
         if ({1'b0, v} >= banks) begin
            v = v - banks[2:0];
         end
      end
      return v;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/hcbd_ram.sv
// ----------------------------------------------------------------------------
// hcbd_ram
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic             we,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> rtl/core/hcbd_decode.sv
// ----------------------------------------------------------------------------
// hcbd_decode
// Address decode of one CPU access against the memory map and local state.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_decode import hcbd_pkg::*; #(
   parameter int RAM_BANKS      = RAM_BANKS_DEFAULT,
   parameter int HIGH_RAM_BYTES = HIGH_RAM_BYTES_DEFAULT,
   localparam int BW            = $clog2(RAM_BANKS),
   localparam int WA            = BW + 12,
   localparam int HA            = $clog2(HIGH_RAM_BYTES)
) (
   input  wire logic        kind,
   input  wire logic [15:0] address,
   input  wire logic [7:0]  wdata,
   input  wire state_type   state,
   output decode_type       dec,
   output logic [WA-1:0]    wram_addr,
   output logic [HA-1:0]    hram_addr
);

   logic [2:0] bank_mod;
   logic [7:0] io;
   tgt_type    io_tgt;

   assign bank_mod  = bank_wrap(state.ram_bank, 4'(RAM_BANKS));
   assign io        = address[7:0];
   assign hram_addr = HA'(io - IO_HRAM_LO);

   always_comb begin
      priority if (io == IO_PAD) begin
         io_tgt = TGT_PAD;
      end else if (io >= IO_TIMER_LO && io <= IO_TIMER_HI) begin
         io_tgt = TGT_TIMER;
      end else if (io == IO_IFLAG) begin
         io_tgt = TGT_IFLAG;
      end else if (io >= IO_APU_LO && io <= IO_APU_HI) begin
         io_tgt = TGT_APU;
      end else if (io >= IO_WAVE_LO && io <= IO_WAVE_HI) begin
         io_tgt = TGT_WAVE;
      end else if ((io >= IO_PPU_LO && io <= IO_PPU_HI && !(kind && io == IO_LY))
                   || io == IO_VBANK || (io >= IO_PAL_LO && io <= IO_PAL_HI)) begin
         io_tgt = TGT_PPU;
      end else if (io == IO_SPEED && (kind || !state.mode_byte[MODE_COMPAT_BIT])) begin
         io_tgt = TGT_SPEED;
      end else if (kind ? (io >= IO_DMA_LO && io <= IO_DMA_HI) : (io == IO_DMA_HI)) begin
         io_tgt = TGT_DMA;
      end else if (io == IO_IE) begin
         io_tgt = TGT_IE;
      end else begin
         io_tgt = TGT_LOCAL;
      end
   end

   always_comb begin
      logic        local_hit;
      logic [14:0] off;
      tgt_type     tgt;
      logic [7:0]  rd;
      src_type     src;
      logic        wram;
      logic        hram;

      local_hit = 1'b0;
      off       = '0;
      tgt       = TGT_LOCAL;
      rd        = BYTE_ZERO;
      src       = SRC_CONST;
      wram      = 1'b0;
      hram      = 1'b0;
      wram_addr = WA'(address[11:0]);
      dec       = '0;

      priority if (!address[15]) begin
         if (state.boot_mapped && (address[15:8] == 8'h00 || address[15:9] != 7'd0)) begin
            if (!kind) begin
               tgt = TGT_BOOT;
               off = address[14:0];
            end
         end else if (state.cart_present) begin
            tgt = TGT_CROM;
            off = address[14:0];
         end else begin
            rd        = BYTE_ONES;
            local_hit = 1'b1;
         end
      end else if (address[15:13] == 3'b100) begin
         tgt = TGT_VRAM;
         off = 15'(address[12:0]);
      end else if (address[15:13] == 3'b101) begin
         if (state.cart_present) begin
            tgt = TGT_CRAM;
            off = 15'(address[12:0]);
         end else begin
            rd        = BYTE_ONES;
            local_hit = 1'b1;
         end
      end else if (address[15:12] == 4'hC || address[15:12] == 4'hE) begin
         wram = 1'b1;
      end else if (address[15:12] == 4'hD) begin
         wram      = 1'b1;
         wram_addr = {bank_mod[BW-1:0], address[11:0]};
      end else if (address[15:8] == 8'hFD) begin
         wram      = 1'b1;
         wram_addr = WA'(address[12:0]);
      end else if (address[15:8] == 8'hFE) begin
         tgt = TGT_OAM;
         off = 15'(io);
      end else if (address[15:8] == 8'hFF) begin
         tgt = io_tgt;
         if (io_tgt == TGT_WAVE) begin
            off = 15'(io - IO_WAVE_LO);
         end else begin
            off = 15'(io);
         end
         if (io_tgt == TGT_LOCAL) begin
            local_hit = 1'b1;
            priority if (io == IO_MODE) begin
               rd           = state.mode_byte;
               dec.mode_we  = kind && state.boot_mapped;
            end else if (io == IO_BOOT) begin
               rd             = 8'(state.boot_mapped);
               dec.boot_clear = kind;
            end else if (io == IO_BANK) begin
               rd          = 8'(state.ram_bank);
               dec.bank_we = kind;
            end else if (io >= IO_HRAM_LO && io <= IO_HRAM_HI) begin
               hram = 1'b1;
            end else begin
               rd = BYTE_ONES;
            end
         end
      end else begin
         local_hit = 1'b1;
      end

      if (wram || hram) begin
         local_hit = 1'b1;
      end

      dec.target       = tgt;
      dec.offset       = (tgt == TGT_LOCAL) ? 15'd0 : off;
      dec.forward_data = (kind && tgt != TGT_LOCAL)
                         ? ((tgt == TGT_SPEED) ? {7'd0, wdata[0]} : wdata) : BYTE_ZERO;
      dec.local_valid  = !kind && local_hit;
      dec.const_data   = (!kind && local_hit) ? rd : BYTE_ZERO;
      if (!kind && wram) begin
         src = SRC_WRAM;
      end else if (!kind && hram) begin
         src = SRC_HRAM;
      end
      dec.src          = src;
      dec.is_write     = kind;
      dec.wram_hit     = wram;
      dec.hram_hit     = hram;
      dec.bank_value   = (wdata[2:0] == 3'd0) ? 3'd1 : wdata[2:0];
   end

endmodule

`default_nettype wire

>>> rtl/core/handheld_console_bus_decoder.sv
// ----------------------------------------------------------------------------
// handheld_console_bus_decoder
// Memory map decoder for the console CPU bus with local work and high RAM.
// ----------------------------------------------------------------------------
// Each word on the req_ channel is one CPU read or write. Each produces one
// word on the rsp_ channel: either a target code with offset and forwarded
// write data for another unit, or a locally supplied read byte.
// rsp_valid rises once the word has passed the decode stage and the output
// register: work and high RAM are single-port synchronous memories read at
// the accepting edge, and the output register loads when the decode stage
// advances. One word is accepted per cycle while req_ready is high. A word
// in the decode stage can wait there while the output register is stalled,
// so the block still takes one word while a result waits; it stops taking
// words when both stages are full and rsp_ready is low, and while clearing.
// After reset the clearing pass writes zero to every work RAM entry and high
// RAM; req_ready stays low meanwhile. csr_wen writes cart_present at any time.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module handheld_console_bus_decoder import hcbd_pkg::*; #(
   parameter int RAM_BANKS      = RAM_BANKS_DEFAULT,
   parameter int HIGH_RAM_BYTES = HIGH_RAM_BYTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wen,
   input  wire logic        csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic [15:0] req_address,
   input  wire logic [7:0]  req_wdata,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_target,
   output logic [14:0]      rsp_offset,
   output logic [7:0]       rsp_forward_data,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_local_valid
);

   localparam int WDEPTH = RAM_BANKS * BANK_BYTES;
   localparam int WA     = $clog2(RAM_BANKS) + 12;
   localparam int HA     = $clog2(HIGH_RAM_BYTES);
   localparam logic [WA-1:0] CLR_LAST = WA'(WDEPTH - 1);
   localparam logic [WA-1:0] HR_LIMIT = WA'(HIGH_RAM_BYTES);

   logic          cart_present_ff;
   logic          boot_mapped_ff;
   logic [7:0]    mode_byte_ff;
   logic [2:0]    ram_bank_ff;
   logic          clearing_ff, clearing_in;
   logic [WA-1:0] clr_ff, clr_in;

   logic          s1_v_ff, s1_v_in;
   decode_type    s1_ff;
   logic          out_v_ff, out_v_in;
   tgt_type       out_target_ff;
   logic [14:0]   out_offset_ff;
   logic [7:0]    out_fwd_ff;
   logic [7:0]    out_rdata_ff, out_rdata_in;
   logic          out_local_ff;

   state_type     state;
   decode_type    dec;
   logic [WA-1:0] dec_wram_addr;
   logic [HA-1:0] dec_hram_addr;
   logic          accept;
   logic          advance;

   logic          wram_en, wram_we;
   logic [WA-1:0] wram_addr;
   logic [7:0]    wram_wdata, wram_q;
   logic          hram_en, hram_we;
   logic [HA-1:0] hram_addr;
   logic [7:0]    hram_wdata, hram_q;

   assign state = '{boot_mapped:  boot_mapped_ff,
                    cart_present: cart_present_ff,
                    mode_byte:    mode_byte_ff,
                    ram_bank:     ram_bank_ff};

   hcbd_decode #(
      .RAM_BANKS      (RAM_BANKS),
      .HIGH_RAM_BYTES (HIGH_RAM_BYTES)
   ) u_decode (
      .kind      (req_kind),
      .address   (req_address),
      .wdata     (req_wdata),
      .state     (state),
      .dec       (dec),
      .wram_addr (dec_wram_addr),
      .hram_addr (dec_hram_addr)
   );

   assign advance   = s1_v_ff && (!out_v_ff || rsp_ready);
   assign req_ready = !clearing_ff && (!s1_v_ff || advance);
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (clearing_ff) begin
         wram_en    = 1'b1;
         wram_we    = 1'b1;
         wram_addr  = clr_ff;
         wram_wdata = BYTE_ZERO;
         hram_en    = clr_ff < HR_LIMIT;
         hram_we    = 1'b1;
         hram_addr  = clr_ff[HA-1:0];
         hram_wdata = BYTE_ZERO;
      end else begin
         wram_en    = accept && dec.wram_hit;
         wram_we    = dec.is_write;
         wram_addr  = dec_wram_addr;
         wram_wdata = req_wdata;
         hram_en    = accept && dec.hram_hit;
         hram_we    = dec.is_write;
         hram_addr  = dec_hram_addr;
         hram_wdata = req_wdata;
      end
   end

   hcbd_ram #(
      .WIDTH (8),
      .DEPTH (WDEPTH)
   ) u_work_ram (
      .clock (clock),
      .en    (wram_en),
      .we    (wram_we),
      .addr  (wram_addr),
      .wdata (wram_wdata),
      .rdata (wram_q)
   );

   hcbd_ram #(
      .WIDTH (8),
      .DEPTH (HIGH_RAM_BYTES)
   ) u_high_ram (
      .clock (clock),
      .en    (hram_en),
      .we    (hram_we),
      .addr  (hram_addr),
      .wdata (hram_wdata),
      .rdata (hram_q)
   );

   always_comb begin
      clearing_in = clearing_ff;
      clr_in      = clr_ff;
      if (clearing_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == CLR_LAST) begin
            clearing_in = 1'b0;
         end
      end

      s1_v_in = s1_v_ff;
      if (accept) begin
         s1_v_in = 1'b1;
      end else if (advance) begin
         s1_v_in = 1'b0;
      end

      out_v_in = out_v_ff;
      if (advance) begin
         out_v_in = 1'b1;
      end else if (rsp_ready) begin
         out_v_in = 1'b0;
      end

      unique case (s1_ff.src)
         SRC_WRAM: out_rdata_in = wram_q;
         SRC_HRAM: out_rdata_in = hram_q;
         default:  out_rdata_in = s1_ff.const_data;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cart_present_ff <= 1'b1;
         boot_mapped_ff  <= 1'b1;
         mode_byte_ff    <= BYTE_ZERO;
         ram_bank_ff     <= 3'd1;
         clearing_ff     <= 1'b1;
         clr_ff          <= '0;
         s1_v_ff         <= 1'b0;
         out_v_ff        <= 1'b0;
      end else begin
         clearing_ff <= clearing_in;
         clr_ff      <= clr_in;
         s1_v_ff     <= s1_v_in;
         out_v_ff    <= out_v_in;
         if (csr_wen) begin
            cart_present_ff <= csr_wdata;
         end
         if (accept && dec.mode_we) begin
            mode_byte_ff <= req_wdata;
         end
         if (accept && dec.boot_clear) begin
            boot_mapped_ff <= 1'b0;
         end
         if (accept && dec.bank_we) begin
            ram_bank_ff <= dec.bank_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= dec;
      end
      if (advance) begin
         out_target_ff <= s1_ff.target;
         out_offset_ff <= s1_ff.offset;
         out_fwd_ff    <= s1_ff.forward_data;
         out_rdata_ff  <= out_rdata_in;
         out_local_ff  <= s1_ff.local_valid;
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_target       = out_target_ff;
   assign rsp_offset       = out_offset_ff;
   assign rsp_forward_data = out_fwd_ff;
   assign rsp_read_data    = out_rdata_ff;
   assign rsp_local_valid  = out_local_ff;

   `HCBD_ASSERT(a_bank_nonzero, clock, reset, ram_bank_ff != 3'd0, "RAM bank register is zero")
   `HCBD_ASSERT(a_boot_no_remap, clock, reset, !$rose(boot_mapped_ff), "boot ROM was remapped")
   `HCBD_ASSERT(a_full_stall, clock, reset, (s1_v_ff && out_v_ff && !rsp_ready) |-> !accept, "word accepted while both stages stalled")
   `HCBD_ASSERT(a_local_target, clock, reset, (rsp_valid && rsp_local_valid) |-> (rsp_target == TGT_LOCAL), "local read carries a target")
   `HCBD_ASSERT(a_clear_quiet, clock, reset, clearing_ff |-> (!s1_v_ff && !out_v_ff), "pipeline busy during clearing pass")

endmodule

`default_nettype wire
